[src/cfp_pkg.sv]
// Package of the command frame parser: frame layout, status and state codes,
// control and status structures and the CRC-16 byte update.
// Depends on nothing; used by every module of the parser.
package cfp_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_MSB     = 16'h8000;

  localparam int POS_SYNC1    = 0;
  localparam int POS_SYNC2    = 1;
  localparam int POS_VERSION  = 2;
  localparam int POS_TYPE     = 3;
  localparam int POS_RID0     = 4;
  localparam int POS_RID1     = 5;
  localparam int POS_RID2     = 6;
  localparam int POS_RID3     = 7;
  localparam int POS_COMMAND  = 8;
  localparam int POS_STATUS   = 9;
  localparam int POS_LEN_LO   = 10;
  localparam int POS_LEN_HI   = 11;
  localparam int HEADER_BYTES = 12;
  localparam int FRAME_OVERHEAD = 14;

  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_TYPE_CODE = 4'd1;

  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    FS_NONE     = 2'd0,
    FS_ERROR    = 2'd1,
    FS_COMPLETE = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_SEND
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic rd_start;
    logic send;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic readout_req;
    logic idx_last;
  } dp_status_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/cfp_ctrl.sv]
// Controller of the command frame parser: byte acceptance and payload readout sequencing.
// Depends on cfp_pkg; drives the datapath cfp_datapath through ctrl_cmd_t.
module cfp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  cfp_pkg::dp_status_t   sts,
  output cfp_pkg::ctrl_cmd_t    cmd
);

  cfp_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfp_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_start = 1'b0;
    cmd.send     = 1'b0;
    unique case (state_r)
      cfp_pkg::CS_IDLE: begin
        in_tready  = sts.out_free;
        cmd.accept = in_tvalid && sts.out_free;
        if (cmd.accept && sts.readout_req) begin
          state_nxt = cfp_pkg::CS_READ;
        end
      end
      cfp_pkg::CS_READ: begin
        cmd.rd_start = 1'b1;
        state_nxt    = cfp_pkg::CS_SEND;
      end
      cfp_pkg::CS_SEND: begin
        if (sts.out_free) begin
          cmd.send  = 1'b1;
          state_nxt = sts.idx_last ? cfp_pkg::CS_IDLE : cfp_pkg::CS_READ;
        end
      end
      default: begin
        state_nxt = cfp_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

[src/cfp_datapath.sv]
// Datapath of the command frame parser: frame position, header fields, running CRC,
// payload memory, configuration registers and the output register.
// Depends on cfp_pkg; sequenced by cfp_ctrl.
module cfp_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [7:0]                        in_tdata,
  input  logic                              cfg_valid,
  input  logic [cfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  cfp_pkg::ctrl_cmd_t                cmd,
  output cfp_pkg::dp_status_t               sts
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int PW = $clog2(MAX_PAYLOAD + cfp_pkg::FRAME_OVERHEAD);
  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    exp_ver_r;
  logic [7:0]    cmd_type_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_lo_r;
  logic [7:0]    ver_r, typ_r, command_r, stat_r, len_lo_r;
  logic [31:0]   rid_r;
  logic [LW-1:0] len_r;
  logic [IW-1:0] idx_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [MAX_PAYLOAD];

  logic                           out_valid_r;
  logic [cfp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [PW-1:0]   hdr_end;
  logic [15:0]     len16;
  logic [15:0]     crc_fed;
  logic            in_payload;
  logic            in_crc_lo;
  logic            mem_we;
  logic            frame_ok;
  logic            len_zero;
  logic            readout_req;
  cfp_pkg::frame_status_t byte_status;
  logic            byte_complete;
  logic            out_load;

  assign hdr_end  = PW'(cfp_pkg::HEADER_BYTES) + PW'(len_r);
  assign len16    = {in_tdata, len_lo_r};
  assign crc_fed  = cfp_pkg::crc_feed(crc_r, in_tdata);
  assign len_zero = (len_r == '0);
  assign frame_ok = (ver_r == exp_ver_r) && (typ_r == cmd_type_r) && (stat_r == 8'h00) &&
                    ({in_tdata, crc_lo_r} == crc_r);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    in_payload    = 1'b0;
    in_crc_lo     = 1'b0;
    byte_status   = cfp_pkg::FS_NONE;
    byte_complete = 1'b0;
    readout_req   = 1'b0;
    priority if (pos_r == PW'(cfp_pkg::POS_SYNC1)) begin
      if (in_tdata == cfp_pkg::SYNC_FIRST) begin
        pos_nxt = PW'(cfp_pkg::POS_SYNC2);
      end
    end else if (pos_r == PW'(cfp_pkg::POS_SYNC2)) begin
      if (in_tdata == cfp_pkg::SYNC_SECOND) begin
        pos_nxt = PW'(cfp_pkg::POS_VERSION);
        crc_nxt = cfp_pkg::CRC_INIT;
      end else if (in_tdata != cfp_pkg::SYNC_FIRST) begin
        pos_nxt = PW'(cfp_pkg::POS_SYNC1);
      end
    end else if (pos_r < PW'(cfp_pkg::HEADER_BYTES)) begin
      crc_nxt = crc_fed;
      pos_nxt = pos_r + PW'(1);
      if (pos_r == PW'(cfp_pkg::POS_LEN_HI) && len16 > 16'(MAX_PAYLOAD)) begin
        pos_nxt     = PW'(cfp_pkg::POS_SYNC1);
        crc_nxt     = cfp_pkg::CRC_INIT;
        byte_status = cfp_pkg::FS_ERROR;
      end
    end else if (pos_r < hdr_end) begin
      in_payload = 1'b1;
      crc_nxt    = crc_fed;
      pos_nxt    = pos_r + PW'(1);
    end else if (pos_r == hdr_end) begin
      in_crc_lo = 1'b1;
      pos_nxt   = pos_r + PW'(1);
    end else begin
      pos_nxt = PW'(cfp_pkg::POS_SYNC1);
      crc_nxt = cfp_pkg::CRC_INIT;
      if (!frame_ok) begin
        byte_status = cfp_pkg::FS_ERROR;
      end else if (len_zero) begin
        byte_status   = cfp_pkg::FS_COMPLETE;
        byte_complete = 1'b1;
      end else begin
        readout_req = 1'b1;
      end
    end
  end

  assign sts.readout_req = readout_req;

  assign mem_we = cmd.accept && in_payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r  <= 8'd1;
      cmd_type_r <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfp_pkg::CFG_EXPECTED_VERSION:  exp_ver_r  <= cfg_data;
        cfp_pkg::CFG_COMMAND_TYPE_CODE: cmd_type_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= cfp_pkg::CRC_INIT;
      crc_lo_r <= 8'h00;
    end else if (cmd.accept) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      if (in_crc_lo) begin
        crc_lo_r <= in_tdata;
      end else if (pos_nxt == PW'(cfp_pkg::POS_SYNC1)) begin
        crc_lo_r <= 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      unique case (pos_r)
        PW'(cfp_pkg::POS_VERSION): ver_r          <= in_tdata;
        PW'(cfp_pkg::POS_TYPE):    typ_r          <= in_tdata;
        PW'(cfp_pkg::POS_RID0):    rid_r[7:0]     <= in_tdata;
        PW'(cfp_pkg::POS_RID1):    rid_r[15:8]    <= in_tdata;
        PW'(cfp_pkg::POS_RID2):    rid_r[23:16]   <= in_tdata;
        PW'(cfp_pkg::POS_RID3):    rid_r[31:24]   <= in_tdata;
        PW'(cfp_pkg::POS_COMMAND): command_r      <= in_tdata;
        PW'(cfp_pkg::POS_STATUS):  stat_r         <= in_tdata;
        PW'(cfp_pkg::POS_LEN_LO):  len_lo_r       <= in_tdata;
        PW'(cfp_pkg::POS_LEN_HI):  len_r          <= LW'(len16);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IW'(pos_r - PW'(cfp_pkg::HEADER_BYTES))] <= in_tdata;
    end
    if (cmd.rd_start) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && readout_req) begin
      idx_r <= '0;
    end else if (cmd.send) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  assign sts.idx_last = ((LW'(idx_r) + LW'(1)) == len_r);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_load = (cmd.accept && !readout_req) || cmd.send;

  always_comb begin
    out_data_nxt = '0;
    out_last_nxt = 1'b1;
    if (cmd.send) begin
      out_data_nxt[1:0]   = cfp_pkg::FS_COMPLETE;
      out_data_nxt[33:2]  = rid_r;
      out_data_nxt[41:34] = command_r;
      out_data_nxt[47:42] = 6'(len_r);
      out_data_nxt[55:48] = rd_data_r;
      out_data_nxt[60:56] = 5'(idx_r);
      out_last_nxt        = sts.idx_last;
    end else begin
      out_data_nxt[1:0] = byte_status;
      if (byte_complete) begin
        out_data_nxt[33:2]  = rid_r;
        out_data_nxt[41:34] = command_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[src/command_frame_parser.sv]
// Top level of the command frame parser: byte stream in, frame results out.
// Timing: a byte's result stands in the output register in the cycle after its transaction;
// the first payload result of a good frame follows through the read and send states.
// Throughput: one byte per cycle while hunting and collecting and the output register is free;
// then the payload is read byte by byte from the memory's single port, input held off.
// Reset (rst_n, synchronous, active low) clears the hunt, the CRC and the output valid flag,
// sets the config defaults; header, payload and output data stay, with no clearing pass.
module command_frame_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: data_byte[7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  // out_tdata: status[1:0], request_id[33:2], command[41:34], payload_length[47:42],
  // payload_byte[55:48], payload_index[60:56], zero[63:61]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data
);

  cfp_pkg::ctrl_cmd_t  cmd;
  cfp_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  cfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfp_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[src/cfp_checker.sv]
// Port-level checks of the command frame parser, bound to its top level.
// Depends on cfp_pkg and command_frame_parser.
module cfp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled output transaction changed.");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != cfp_pkg::FS_COMPLETE |->
      out_tlast && out_tdata[63:2] == '0 && out_tdata[1:0] != 2'd3)
    else $error("Result without a completed frame carries data.");

  a_readout_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == cfp_pkg::FS_COMPLETE && !out_tlast |-> !in_tready)
    else $error("Input accepted during payload readout.");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[1:0] == cfp_pkg::FS_COMPLETE && !out_tlast |=>
      !out_tvalid || out_tdata[60:56] == $past(out_tdata[60:56]) + 5'd1)
    else $error("Payload index did not advance by one.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("Configuration port not ready.");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);
